// ===== rtl/bidirectional_bad_char_search_core_assert.svh =====
// Assertion macros used by the checker file rtl/bbcs_checker.sv.
`ifndef BIDIRECTIONAL_BAD_CHAR_SEARCH_CORE_ASSERT_SVH
`define BIDIRECTIONAL_BAD_CHAR_SEARCH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBCS_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBCS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bbcs_pkg.sv =====
`timescale 1ns / 1ps
package bbcs_pkg;

  localparam int CHAR_W = 7;
  localparam int POS_W  = 12;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD_PAT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TXT = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_WALK_RD,
    ST_CMP,
    ST_SKIP,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/bbcs_ram.sv =====
`timescale 1ns / 1ps
module bbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bbcs_step.sv =====
`timescale 1ns / 1ps
module bbcs_step #(
  parameter int PW = 6,
  parameter int TW = 13,
  parameter int IW = 14
) (
  input  logic          backward_i,
  input  logic [IW-1:0] i_i,
  input  logic [PW-1:0] j_i,
  input  logic [PW-1:0] m_i,
  input  logic [TW-1:0] n_i,
  input  logic [PW-1:0] t_i,
  output logic [IW-1:0] next_i_o,
  output logic          fail_o
);

  logic [PW-1:0] lo;
  logic [PW-1:0] step;
  logic [IW-1:0] step_ext;

  always_comb begin
    lo       = backward_i ? (j_i + PW'(1)) : (m_i - j_i);
    step     = (lo > t_i) ? lo : t_i;
    step_ext = IW'(step);
    if (backward_i) begin
      next_i_o = i_i - step_ext;
      fail_o   = step_ext > i_i;
    end else begin
      next_i_o = i_i + step_ext;
      fail_o   = next_i_o >= IW'(n_i);
    end
  end

endmodule

// ===== rtl/bidirectional_bad_char_search_core.sv =====
`timescale 1ns / 1ps
// The core is ready again in the cycle after a load word, but not during a search.
// A search word with an empty pattern or one longer than the text goes straight to FIN;
// else it fills the skip table (BLD_RD, BLD_WR per character), walks the text (WALK_RD,
// CMP, SKIP after a mismatch) and ends in FIN, held while the last result word waits.
// Compares share one comparator and skips one step unit; RAM read latency sets the step.
// Reset clears lengths, load flags and the result valid flag; store contents are kept.
module bidirectional_bad_char_search_core #(
  parameter int MAX_PATTERN = 32,
  parameter int TEXT_DEPTH  = 4096,
  parameter int ALPHABET    = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] ch, [7] zero
  input  logic        s_axis_tlast,
  input  logic [2:0]  s_axis_tuser,   // [1:0] op, [2] backward
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] position, [15:12] zero
  output logic        m_axis_tuser    // [0] found
);

  localparam int PW  = $clog2(MAX_PATTERN + 1);
  localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int TW  = $clog2(TEXT_DEPTH + 1);
  localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int AW  = $clog2(ALPHABET);
  localparam int IW  = $clog2(TEXT_DEPTH + MAX_PATTERN + 1);
  localparam int CW  = bbcs_pkg::CHAR_W;

  bbcs_pkg::state_e state_q, state_d;

  logic [PW-1:0]       plen_q, plen_d;
  logic [TW-1:0]       tlen_q, tlen_d;
  logic                pload_q, pload_d;
  logic                tload_q, tload_d;
  logic                bwd_q, bwd_d;
  logic [PW-1:0]       k_q, k_d;
  logic [IW-1:0]       i_q, i_d;
  logic [PW-1:0]       j_q, j_d;
  logic [CW-1:0]       c_q, c_d;
  logic [ALPHABET-1:0] valid_q, valid_d;
  logic                found_q, found_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic                ovalid_q, ovalid_d;
  logic                ofound_q, ofound_d;
  logic [bbcs_pkg::POS_W-1:0] opos_q, opos_d;

  logic [bbcs_pkg::OP_W-1:0] op;
  logic [CW-1:0]  ch;
  logic           in_acc;
  logic [PW-1:0]  peff;
  logic [TW-1:0]  teff;

  logic           pat_we;
  logic [PAW-1:0] pat_waddr;
  logic [PAW-1:0] pat_raddr;
  logic [CW-1:0]  pat_rdata;
  logic           txt_we;
  logic [TAW-1:0] txt_waddr;
  logic [CW-1:0]  txt_rdata;
  logic           skp_we;
  logic [AW-1:0]  skp_waddr;
  logic [PW-1:0]  skp_rdata;
  logic [PW-1:0]  t_val;
  logic [IW-1:0]  step_next;
  logic           step_fail;
  logic [PW-1:0]  bld_idx;

  assign op     = s_axis_tuser[1:0];
  assign ch     = s_axis_tdata[CW-1:0];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign peff   = pload_q ? plen_q : '0;
  assign teff   = tload_q ? tlen_q : '0;

  assign s_axis_tready = (state_q == bbcs_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ofound_q;
  assign m_axis_tdata  = 16'(opos_q);

  assign bld_idx   = bwd_q ? k_q : (plen_q - PW'(1) - k_q);
  assign pat_raddr = (state_q == bbcs_pkg::ST_BLD_RD) ? bld_idx[PAW-1:0] : j_q[PAW-1:0];
  assign pat_waddr = peff[PAW-1:0];
  assign txt_waddr = teff[TAW-1:0];
  assign skp_waddr = AW'(pat_rdata);
  assign t_val     = valid_q[AW'(c_q)] ? skp_rdata : plen_q;

  bbcs_ram #(.WIDTH(CW), .DEPTH(MAX_PATTERN)) u_pat (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (ch),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  bbcs_ram #(.WIDTH(CW), .DEPTH(TEXT_DEPTH)) u_txt (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (txt_waddr),
    .wdata_i (ch),
    .raddr_i (i_q[TAW-1:0]),
    .rdata_o (txt_rdata)
  );

  bbcs_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_skp (
    .clk_i   (clk_i),
    .we_i    (skp_we),
    .waddr_i (skp_waddr),
    .wdata_i (k_q),
    .raddr_i (AW'(txt_rdata)),
    .rdata_o (skp_rdata)
  );

  bbcs_step #(.PW(PW), .TW(TW), .IW(IW)) u_step (
    .backward_i (bwd_q),
    .i_i        (i_q),
    .j_i        (j_q),
    .m_i        (plen_q),
    .n_i        (tlen_q),
    .t_i        (t_val),
    .next_i_o   (step_next),
    .fail_o     (step_fail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bbcs_pkg::ST_IDLE;
      plen_q   <= '0;
      tlen_q   <= '0;
      pload_q  <= 1'b0;
      tload_q  <= 1'b0;
      valid_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      plen_q   <= plen_d;
      tlen_q   <= tlen_d;
      pload_q  <= pload_d;
      tload_q  <= tload_d;
      valid_q  <= valid_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bwd_q    <= bwd_d;
    k_q      <= k_d;
    i_q      <= i_d;
    j_q      <= j_d;
    c_q      <= c_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
    ofound_q <= ofound_d;
    opos_q   <= opos_d;
  end

  always_comb begin
    state_d  = state_q;
    plen_d   = plen_q;
    tlen_d   = tlen_q;
    pload_d  = pload_q;
    tload_d  = tload_q;
    bwd_d    = bwd_q;
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    c_d      = c_q;
    valid_d  = valid_q;
    found_d  = found_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q;
    ofound_d = ofound_q;
    opos_d   = opos_q;
    pat_we   = 1'b0;
    txt_we   = 1'b0;
    skp_we   = 1'b0;

    if (m_axis_tvalid && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      bbcs_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            bbcs_pkg::OP_LOAD_PAT: begin
              pload_d = !s_axis_tlast;
              plen_d  = peff;
              if (peff < PW'(MAX_PATTERN)) begin
                pat_we = 1'b1;
                plen_d = peff + PW'(1);
              end
            end
            bbcs_pkg::OP_LOAD_TXT: begin
              tload_d = !s_axis_tlast;
              tlen_d  = teff;
              if (teff < TW'(TEXT_DEPTH)) begin
                txt_we = 1'b1;
                tlen_d = teff + TW'(1);
              end
            end
            bbcs_pkg::OP_SEARCH: begin
              bwd_d   = s_axis_tuser[2];
              valid_d = '0;
              found_d = 1'b0;
              pos_d   = '0;
              k_d     = plen_q - PW'(1);
              if (plen_q == '0 || TW'(plen_q) > tlen_q) begin
                state_d = bbcs_pkg::ST_FIN;
              end else begin
                state_d = bbcs_pkg::ST_BLD_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bbcs_pkg::ST_BLD_RD: begin
        state_d = bbcs_pkg::ST_BLD_WR;
      end
      bbcs_pkg::ST_BLD_WR: begin
        skp_we = 1'b1;
        valid_d[skp_waddr] = 1'b1;
        if (k_q == '0) begin
          if (bwd_q) begin
            i_d = IW'(tlen_q) - IW'(plen_q);
            j_d = '0;
          end else begin
            i_d = IW'(plen_q) - IW'(1);
            j_d = plen_q - PW'(1);
          end
          state_d = bbcs_pkg::ST_WALK_RD;
        end else begin
          k_d     = k_q - PW'(1);
          state_d = bbcs_pkg::ST_BLD_RD;
        end
      end
      bbcs_pkg::ST_WALK_RD: begin
        state_d = bbcs_pkg::ST_CMP;
      end
      bbcs_pkg::ST_CMP: begin
        if (txt_rdata == pat_rdata) begin
          if (bwd_q ? (j_q == plen_q - PW'(1)) : (j_q == '0)) begin
            found_d = 1'b1;
            pos_d   = i_q - IW'(j_q);
            state_d = bbcs_pkg::ST_FIN;
          end else begin
            i_d     = bwd_q ? (i_q + IW'(1)) : (i_q - IW'(1));
            j_d     = bwd_q ? (j_q + PW'(1)) : (j_q - PW'(1));
            state_d = bbcs_pkg::ST_WALK_RD;
          end
        end else begin
          c_d     = txt_rdata;
          state_d = bbcs_pkg::ST_SKIP;
        end
      end
      bbcs_pkg::ST_SKIP: begin
        if (step_fail) begin
          state_d = bbcs_pkg::ST_FIN;
        end else begin
          i_d     = step_next;
          j_d     = bwd_q ? '0 : (plen_q - PW'(1));
          state_d = bbcs_pkg::ST_WALK_RD;
        end
      end
      bbcs_pkg::ST_FIN: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ofound_d = found_q;
          opos_d   = bbcs_pkg::POS_W'(pos_q);
          state_d  = bbcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bbcs_checker.sv =====
`timescale 1ns / 1ps
`include "bidirectional_bad_char_search_core_assert.svh"
module bbcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic in_acc;
  logic unused;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign unused = ^{s_axis_tdata, s_axis_tlast};

  `BBCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BBCS_ASSERT_SAME(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'd0)
  `BBCS_ASSERT_NEXT(a_search_busy, in_acc && s_axis_tuser[1:0] == bbcs_pkg::OP_SEARCH, !s_axis_tready)
  `BBCS_ASSERT_NEXT(a_load_silent, in_acc && s_axis_tuser[1:0] != bbcs_pkg::OP_SEARCH && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind bidirectional_bad_char_search_core bbcs_checker u_bbcs_checker (.*);

// ===== tb/search_checker.sv =====
`timescale 1ns / 1ps
module search_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int PAT_CAP = 32;
  localparam int TXT_CAP = 4096;

  typedef struct packed {
    logic                       found;
    logic [bbcs_pkg::POS_W-1:0] position;
  } match_t;

  logic [bbcs_pkg::CHAR_W-1:0] pat_mem [PAT_CAP];
  logic [bbcs_pkg::CHAR_W-1:0] txt_mem [TXT_CAP];
  int                pat_len;
  int                txt_len;
  logic              pat_busy;
  logic              txt_busy;
  match_t            match_q[$];

  function automatic int find_match(input logic back);
    int shift_tab [128];
    int m;
    int n;
    int i;
    int j;
    int t;
    int lo;
    int p;
    m = pat_len;
    n = txt_len;
    for (int k = 0; k < 128; k++) shift_tab[k] = m;
    for (int k = 0; k < m; k++) begin
      p = back ? k : m - 1 - k;
      if (shift_tab[pat_mem[p]] == m) shift_tab[pat_mem[p]] = k;
    end
    if (!back) begin
      i = m - 1;
      j = m - 1;
      while (j >= 0) begin
        while (txt_mem[i] != pat_mem[j]) begin
          t = shift_tab[txt_mem[i]];
          lo = m - j;
          i += (lo > t) ? lo : t;
          if (i >= n) return -1;
          j = m - 1;
        end
        i--;
        j--;
      end
      return i + 1;
    end
    i = n - m;
    j = 0;
    while (j < m) begin
      while (txt_mem[i] != pat_mem[j]) begin
        t = shift_tab[txt_mem[i]];
        lo = j + 1;
        i -= (lo > t) ? lo : t;
        if (i < 0) return -1;
        j = 0;
      end
      i++;
      j++;
    end
    return i - m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [bbcs_pkg::OP_W-1:0] op;
    int              pos;
    match_t          want;
    match_t          got;
    if (!rst_ni) begin
      pat_len <= 0;
      txt_len <= 0;
      pat_busy <= 1'b0;
      txt_busy <= 1'b0;
      fail_count_o <= 0;
      pending_o <= 0;
      match_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        op = s_axis_tuser[1:0];
        if (op == bbcs_pkg::OP_LOAD_PAT) begin
          pos = pat_busy ? pat_len : 0;
          if (pos < PAT_CAP) begin
            pat_mem[pos] = s_axis_tdata[6:0];
            pos++;
          end
          pat_len <= pos;
          pat_busy <= !s_axis_tlast;
        end else if (op == bbcs_pkg::OP_LOAD_TXT) begin
          pos = txt_busy ? txt_len : 0;
          if (pos < TXT_CAP) begin
            txt_mem[pos] = s_axis_tdata[6:0];
            pos++;
          end
          txt_len <= pos;
          txt_busy <= !s_axis_tlast;
        end else if (op == bbcs_pkg::OP_SEARCH) begin
          pos = -1;
          if (pat_len != 0 && pat_len <= txt_len) pos = find_match(s_axis_tuser[2]);
          want.found = pos >= 0;
          want.position = pos >= 0 ? pos[bbcs_pkg::POS_W-1:0] : '0;
          match_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser;
        got.position = m_axis_tdata[bbcs_pkg::POS_W-1:0];
        if (match_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result word found=%0d pos=%0d",
                                          got.found, got.position);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = match_q.pop_front();
          if (got !== want || m_axis_tdata[15:12] !== 4'd0) begin
            if (fail_count_o < 10)
              $display("mismatch: expected found=%0d pos=%0d, got found=%0d pos=%0d",
                       want.found, want.position, got.found, got.position);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= match_q.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          sent;
  logic [6:0]  pat_buf [40];

  bidirectional_bad_char_search_core dut (.*);

  search_checker checker_u (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG) begin
      $display("bidirectional_bad_char_search_core regression: fail");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && !m_axis_tready) begin
        wait_cycles = $urandom_range(0, 6);
        repeat (wait_cycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        do @(posedge clk_i); while (!m_axis_tvalid);
        m_axis_tready <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [bbcs_pkg::OP_W-1:0] op, input logic [6:0] ch,
                           input logic last, input logic back);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ch};
    s_axis_tlast <= last;
    s_axis_tuser <= {back, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic load_pattern(input int len);
    for (int k = 0; k < len; k++)
      send_word(bbcs_pkg::OP_LOAD_PAT, pat_buf[k], k == len - 1, 1'($urandom));
  endtask

  task automatic load_text(input int len, input int alpha, input int plant_at, input int plen);
    logic [6:0] c;
    for (int k = 0; k < len; k++) begin
      c = 7'($urandom_range(0, alpha - 1));
      if (k >= plant_at && k < plant_at + plen) c = pat_buf[k - plant_at];
      send_word(bbcs_pkg::OP_LOAD_TXT, c, k == len - 1, 1'($urandom));
    end
  endtask

  initial begin
    int plen;
    int tlen;
    int alpha;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = '0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(bbcs_pkg::OP_SEARCH, 7'h7f, 1'b1, 1'b0);
    pat_buf[0] = 7'h7f;
    pat_buf[1] = 7'h00;
    load_pattern(2);
    send_word(bbcs_pkg::OP_SEARCH, 7'h00, 1'b0, 1'b1);
    load_text(4, 1, 1, 2);
    send_word(bbcs_pkg::OP_SEARCH, 7'h55, 1'b0, 1'b0);
    send_word(bbcs_pkg::OP_SEARCH, 7'h2a, 1'b1, 1'b1);
    send_word(bbcs_pkg::OP_NONE, 7'h7f, 1'b1, 1'b1);
    for (int k = 0; k < 34; k++) pat_buf[k] = (k % 2) ? 7'h7f : 7'h00;
    load_pattern(34);
    load_text(40, 1, 3, 32);
    send_word(bbcs_pkg::OP_SEARCH, 7'h0, 1'b0, 1'b0);
    send_word(bbcs_pkg::OP_SEARCH, 7'h0, 1'b0, 1'b1);
    pat_buf[0] = 7'h11;
    send_word(bbcs_pkg::OP_LOAD_PAT, 7'h11, 1'b0, 1'b0);
    send_word(bbcs_pkg::OP_SEARCH, 7'h0, 1'b0, 1'b1);
    send_word(bbcs_pkg::OP_LOAD_PAT, 7'h22, 1'b1, 1'b0);
    while (sent < 950) begin
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 4);
      tlen = $urandom_range(1, 24);
      alpha = $urandom_range(0, 1) ? $urandom_range(1, 4) : 128;
      for (int k = 0; k < plen; k++) pat_buf[k] = 7'($urandom_range(0, alpha - 1));
      if ($urandom_range(0, 3) != 0) load_pattern(plen);
      if ($urandom_range(0, 3) != 0)
        load_text(tlen, alpha, (tlen > plen) ? $urandom_range(0, tlen - plen) : 0,
                  $urandom_range(0, 2) ? plen : 0);
      if ($urandom_range(0, 9) == 0)
        send_word(bbcs_pkg::OP_NONE, 7'($urandom), 1'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3))
        send_word(bbcs_pkg::OP_SEARCH, 7'($urandom), 1'($urandom), 1'($urandom));
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bidirectional_bad_char_search_core regression: pass");
    end else begin
      $display("bidirectional_bad_char_search_core regression: fail");
    end
    $finish;
  end
endmodule
